>>> hdl/stp_pkg.sv
`default_nettype none
package stp_pkg;

   localparam int unsigned TW = 32;

   typedef enum logic [2:0] {
      CMD_CREATE  = 3'd0,
      CMD_RESET   = 3'd1,
      CMD_RELEASE = 3'd2,
      CMD_KEY     = 3'd3,
      CMD_POLL    = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACK      = 3'd0,
      KIND_INIT     = 3'd1,
      KIND_PROGRESS = 3'd2,
      KIND_TIMEOUT  = 3'd3,
      KIND_PERIODIC = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CREATE,
      OP_LOAD,
      OP_FREE,
      OP_MARK
   } op_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_FREE,
      IDX_BEST,
      IDX_RANK
   } idx_sel_type;

   typedef struct packed {
      logic [2:0]    command;
      logic [TW-1:0] now_time;
      logic [TW-1:0] target_id;
      logic [TW-1:0] duration;
      logic [TW-1:0] period;
      logic          free_on_timeout;
      logic [3:0]    event_enables;
      logic [TW-1:0] user_tag;
      logic [TW-1:0] group_key;
   } req_type;

   typedef struct packed {
      logic [2:0]    kind;
      logic [TW-1:0] timer_id;
      logic [TW-1:0] tag_out;
      logic [1:0]    status;
      logic          last;
   } rsp_type;

   typedef struct packed {
      logic        latch_req;
      op_type      op;
      idx_sel_type idx_sel;
      logic        scan_clear;
      logic        scan_step;
      logic        walk_start;
      logic        walk_next;
      logic        emit;
      kind_type    emit_kind;
      logic        emit_use_slot;
      status_type  emit_status;
      logic        emit_last;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       free_avail;
      logic       found;
      logic       scan_last;
      logic       walk_done;
      logic       key_zero;
      logic       key_match;
      logic       timed_out;
      logic       periodic_due;
      logic [4:0] flags;
      logic       out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> hdl/software_timer_pool_top.sv
`default_nettype none
// Pool of NUM_TIMERS timer slots driven by command words on req_*.
// Each accepted word carries the current time; the block answers with zero
// or more event words on rsp_* and always closes with an acknowledge word
// that has last set.
// req_ready is high only while no command is in work; rsp_* is a single
// output register, so the next command is taken while the closing
// acknowledge still waits for rsp_ready.
// Reset and release scan every slot through the one slot read port, one per
// cycle; poll and release by key walk the live timers oldest first.
// A stalled receiver holds the machine at its next event word.
// Reset empties the pool, sets the next ID to one and drops any pending
// response.
module software_timer_pool_top #(
   parameter int unsigned NUM_TIMERS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire stp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output stp_pkg::rsp_type      rsp_data
);
   import stp_pkg::*;

   ctl_type ctl;
   sts_type sts;

   stp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   stp_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> hdl/stp_ctrl.sv
`default_nettype none
module stp_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire stp_pkg::sts_type sts,
   output stp_pkg::ctl_type     ctl
);
   import stp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_FOUND, S_RESET_DO, S_RELEASE_DO,
      S_INIT_EV, S_WALK, S_VISIT, S_PERIODIC, S_ACK
   } state_type;

   state_type  state_ff, state_in;
   status_type ack_status_ff, ack_status_in;
   logic       ack_use_ff, ack_use_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ack_status_ff <= ST_OK;
         ack_use_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ack_status_ff <= ack_status_in;
         ack_use_ff    <= ack_use_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ack_status_in = ack_status_ff;
      ack_use_in    = ack_use_ff;
      req_ready     = 1'b0;
      ctl           = '0;
      ctl.op        = OP_NONE;
      ctl.idx_sel   = IDX_HOLD;
      ctl.emit_kind = KIND_ACK;
      ctl.emit_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ack_status_in = ST_OK;
            ack_use_in    = 1'b0;
            state_in      = S_ACK;
            case (sts.cmd)
               CMD_CREATE: begin
                  if (sts.free_avail) begin
                     ctl.op      = OP_CREATE;
                     ctl.idx_sel = IDX_FREE;
                     state_in    = S_INIT_EV;
                  end else begin
                     ack_status_in = ST_FULL;
                  end
               end
               CMD_RESET, CMD_RELEASE: begin
                  ctl.idx_sel    = IDX_ZERO;
                  ctl.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end
               CMD_KEY: begin
                  if (!sts.key_zero) begin
                     ctl.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               CMD_POLL: begin
                  ctl.walk_start = 1'b1;
                  state_in       = S_WALK;
               end
               default: state_in = S_ACK;
            endcase
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) state_in = S_FOUND;
         end
         S_FOUND: begin
            if (sts.found) begin
               ctl.idx_sel = IDX_BEST;
               state_in    = (sts.cmd == CMD_RESET) ? S_RESET_DO : S_RELEASE_DO;
            end else begin
               ack_status_in = ST_NOTFOUND;
               ack_use_in    = 1'b0;
               state_in      = S_ACK;
            end
         end
         S_RESET_DO: begin
            ctl.op   = OP_LOAD;
            state_in = S_INIT_EV;
         end
         S_RELEASE_DO: begin
            ctl.op        = OP_FREE;
            ack_status_in = ST_OK;
            ack_use_in    = 1'b1;
            state_in      = S_ACK;
         end
         S_INIT_EV: begin
            ack_status_in = ST_OK;
            ack_use_in    = 1'b1;
            if (!sts.flags[0]) begin
               state_in = S_ACK;
            end else if (sts.out_free) begin
               ctl.emit          = 1'b1;
               ctl.emit_kind     = KIND_INIT;
               ctl.emit_use_slot = 1'b1;
               state_in          = S_ACK;
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               ack_status_in = ST_OK;
               ack_use_in    = 1'b0;
               state_in      = S_ACK;
            end else begin
               ctl.idx_sel = IDX_RANK;
               state_in    = S_VISIT;
            end
         end
         S_VISIT: begin
            if (sts.cmd == CMD_KEY) begin
               ctl.walk_next = 1'b1;
               if (sts.key_match) ctl.op = OP_FREE;
               state_in = S_WALK;
            end else if (sts.timed_out) begin
               if (!sts.flags[2] || sts.out_free) begin
                  ctl.emit          = sts.flags[2];
                  ctl.emit_kind     = KIND_TIMEOUT;
                  ctl.emit_use_slot = 1'b1;
                  ctl.walk_next     = 1'b1;
                  if (sts.flags[4]) ctl.op = OP_FREE;
                  state_in = S_WALK;
               end
            end else if (!sts.flags[1]) begin
               state_in = S_PERIODIC;
            end else if (sts.out_free) begin
               ctl.emit          = 1'b1;
               ctl.emit_kind     = KIND_PROGRESS;
               ctl.emit_use_slot = 1'b1;
               state_in          = S_PERIODIC;
            end
         end
         S_PERIODIC: begin
            if (!(sts.flags[3] && sts.periodic_due)) begin
               ctl.walk_next = 1'b1;
               state_in      = S_WALK;
            end else if (sts.out_free) begin
               ctl.emit          = 1'b1;
               ctl.emit_kind     = KIND_PERIODIC;
               ctl.emit_use_slot = 1'b1;
               ctl.op            = OP_MARK;
               ctl.walk_next     = 1'b1;
               state_in          = S_WALK;
            end
         end
         S_ACK: begin
            if (sts.out_free) begin
               ctl.emit          = 1'b1;
               ctl.emit_kind     = KIND_ACK;
               ctl.emit_use_slot = ack_use_ff;
               ctl.emit_status   = ack_status_ff;
               ctl.emit_last     = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/stp_datapath.sv
`default_nettype none
module stp_datapath #(
   parameter int unsigned NUM_TIMERS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stp_pkg::req_type  req_data,
   input  wire stp_pkg::ctl_type  ctl,
   output stp_pkg::sts_type       sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output stp_pkg::rsp_type       rsp_data
);
   import stp_pkg::*;

   localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

   function automatic logic [TW-1:0] since(input logic [TW-1:0] now,
                                           input logic [TW-1:0] then_t);
      logic [TW-1:0] d;
      d = (now < then_t) ? (now + ~then_t) : (now - then_t);
      return d;
   endfunction

   req_type       req_ff;
   logic          live_ff   [NUM_TIMERS];
   logic [TW-1:0] id_ff     [NUM_TIMERS];
   logic [TW-1:0] start_ff  [NUM_TIMERS];
   logic [TW-1:0] dur_ff    [NUM_TIMERS];
   logic [TW-1:0] per_ff    [NUM_TIMERS];
   logic [TW-1:0] lastp_ff  [NUM_TIMERS];
   logic [TW-1:0] tag_ff    [NUM_TIMERS];
   logic [TW-1:0] key_ff    [NUM_TIMERS];
   logic [4:0]    flags_ff  [NUM_TIMERS];
   logic [IW-1:0] age_ff    [NUM_TIMERS];
   logic [TW-1:0] next_id_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] idx_ff, best_ff, best_age_ff, rank_ff;
   logic          found_ff;
   logic [CW-1:0] remain_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [IW-1:0] free_idx, rank_idx;
   logic          free_avail, hit, out_free;

   always_comb begin
      free_idx   = '0;
      rank_idx   = '0;
      free_avail = 1'b0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_idx   = IW'(i);
            free_avail = 1'b1;
         end
         if (live_ff[i] && age_ff[i] == rank_ff) rank_idx = IW'(i);
      end
   end

   assign hit = live_ff[idx_ff] && (id_ff[idx_ff] == req_ff.target_id) &&
                (req_ff.target_id != '0) && (!found_ff || age_ff[idx_ff] < best_age_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.cmd          = req_ff.command;
      sts.free_avail   = free_avail;
      sts.found        = found_ff;
      sts.scan_last    = (idx_ff == IW'(NUM_TIMERS - 1));
      sts.walk_done    = (remain_ff == '0);
      sts.key_zero     = (req_ff.group_key == '0);
      sts.key_match    = (key_ff[idx_ff] == req_ff.group_key);
      sts.timed_out    = (dur_ff[idx_ff] != '0) &&
                         (since(req_ff.now_time, start_ff[idx_ff]) >= dur_ff[idx_ff]);
      sts.periodic_due = (since(req_ff.now_time, lastp_ff[idx_ff]) >= per_ff[idx_ff]);
      sts.flags        = flags_ff[idx_ff];
      sts.out_free     = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) live_ff[i] <= 1'b0;
         next_id_ff   <= TW'(1);
         count_ff     <= '0;
         found_ff     <= 1'b0;
         remain_ff    <= '0;
         rank_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (ctl.idx_sel)
            IDX_ZERO: idx_ff <= '0;
            IDX_FREE: idx_ff <= free_idx;
            IDX_BEST: idx_ff <= best_ff;
            IDX_RANK: idx_ff <= rank_idx;
            default: begin
               if (ctl.scan_step && !sts.scan_last) idx_ff <= idx_ff + 1'b1;
            end
         endcase
         if (ctl.scan_clear) found_ff <= 1'b0;
         else if (ctl.scan_step && hit) found_ff <= 1'b1;
         if (ctl.walk_start) begin
            rank_ff   <= '0;
            remain_ff <= count_ff;
         end else if (ctl.walk_next) begin
            remain_ff <= remain_ff - 1'b1;
            if (ctl.op != OP_FREE) rank_ff <= rank_ff + 1'b1;
         end
         case (ctl.op)
            OP_CREATE: begin
               live_ff[free_idx] <= 1'b1;
               next_id_ff <= (next_id_ff == '1) ? TW'(1) : next_id_ff + 1'b1;
               count_ff   <= count_ff + 1'b1;
            end
            OP_FREE: begin
               live_ff[idx_ff] <= 1'b0;
               if (count_ff != '0) count_ff <= count_ff - 1'b1;
            end
            default: ;
         endcase
         if (ctl.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_req) req_ff <= req_data;
      if (ctl.scan_step && hit) begin
         best_ff     <= idx_ff;
         best_age_ff <= age_ff[idx_ff];
      end
      case (ctl.op)
         OP_CREATE: begin
            id_ff[free_idx]    <= next_id_ff;
            key_ff[free_idx]   <= req_ff.group_key;
            age_ff[free_idx]   <= count_ff[IW-1:0];
            start_ff[free_idx] <= req_ff.now_time;
            lastp_ff[free_idx] <= req_ff.now_time;
            dur_ff[free_idx]   <= req_ff.duration;
            per_ff[free_idx]   <= req_ff.period;
            tag_ff[free_idx]   <= req_ff.user_tag;
            flags_ff[free_idx] <= {req_ff.free_on_timeout, req_ff.event_enables};
         end
         OP_LOAD: begin
            start_ff[idx_ff] <= req_ff.now_time;
            lastp_ff[idx_ff] <= req_ff.now_time;
            dur_ff[idx_ff]   <= req_ff.duration;
            per_ff[idx_ff]   <= req_ff.period;
            tag_ff[idx_ff]   <= req_ff.user_tag;
            flags_ff[idx_ff] <= {req_ff.free_on_timeout, req_ff.event_enables};
         end
         OP_FREE: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               if (live_ff[i] && age_ff[i] > age_ff[idx_ff]) age_ff[i] <= age_ff[i] - 1'b1;
            end
         end
         OP_MARK: lastp_ff[idx_ff] <= req_ff.now_time;
         default: ;
      endcase
      if (ctl.emit) begin
         rsp_ff.kind     <= ctl.emit_kind;
         rsp_ff.timer_id <= ctl.emit_use_slot ? id_ff[idx_ff] : '0;
         rsp_ff.tag_out  <= ctl.emit_use_slot ? tag_ff[idx_ff] : '0;
         rsp_ff.status   <= ctl.emit_status;
         rsp_ff.last     <= ctl.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/stp_checker.sv
`default_nettype none
module stp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire stp_pkg::rsp_type rsp_data
);
   import stp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command taken while one is in work");

   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.kind == KIND_ACK)
      else $error("last set on an event word");

   a_event_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_ACK |-> !rsp_data.last && rsp_data.status == ST_OK)
      else $error("event word with status or last set");

endmodule

bind software_timer_pool_top stp_checker u_stp_checker (.*);
`default_nettype wire

>>> sim/software_timer_pool_top_tb.sv
`default_nettype none
module software_timer_pool_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stp_pkg::*;

   localparam int unsigned SLOTS = 16;
   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam logic [TW-1:0] ID_TOP = 32'hFFFF_FFFF;
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned HOLDOFF_CYCLES = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   software_timer_pool_top #(.NUM_TIMERS(SLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // timer pool mirror
   logic          t_live   [SLOTS];
   logic [TW-1:0] t_id     [SLOTS];
   logic [TW-1:0] t_start  [SLOTS];
   logic [TW-1:0] t_dur    [SLOTS];
   logic [TW-1:0] t_per    [SLOTS];
   logic [TW-1:0] t_mark   [SLOTS];
   logic [TW-1:0] t_tag    [SLOTS];
   logic [TW-1:0] t_key    [SLOTS];
   logic [4:0]    t_flags  [SLOTS];
   int unsigned   t_rank   [SLOTS];
   logic [TW-1:0] id_next = 1;
   int unsigned   n_live = 0;

   req_type     cmd_queue[$];
   rsp_type     event_queue[$];
   int unsigned errors = 0;
   bit          idling = 1'b1;
   bit          holdoff_req = 1'b0;
   bit          holdoff_done = 1'b0;
   int unsigned holdoff_left = 0;
   int unsigned quiet_cycles = 0;
   logic [TW-1:0] clk_now = 0;

   initial for (int i = 0; i < SLOTS; i++) t_live[i] = 1'b0;

   function automatic logic [TW-1:0] elapsed(logic [TW-1:0] now, logic [TW-1:0] then);
      logic [TW-1:0] d;
      d = now - then;
      if (now < then) d = d - 1;
      return d;
   endfunction

   function automatic void push_event(kind_type k, logic [TW-1:0] id,
                                      logic [TW-1:0] tg, status_type st, logic lst);
      rsp_type r;
      r.kind = k; r.timer_id = id; r.tag_out = tg; r.status = st; r.last = lst;
      event_queue.push_back(r);
   endfunction

   function automatic int find_id(logic [TW-1:0] id);
      int best;
      best = -1;
      if (id == 0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (t_live[i] && t_id[i] == id && (best < 0 || t_rank[i] < t_rank[best]))
            best = i;
      return best;
   endfunction

   function automatic void drop_slot(int s);
      t_live[s] = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (t_live[i] && t_rank[i] > t_rank[s]) t_rank[i]--;
      if (n_live > 0) n_live--;
   endfunction

   function automatic void load(int s, req_type r);
      t_start[s] = r.now_time;
      t_mark[s]  = r.now_time;
      t_dur[s]   = r.duration;
      t_per[s]   = r.period;
      t_tag[s]   = r.user_tag;
      t_flags[s] = {r.free_on_timeout, r.event_enables};
   endfunction

   function automatic void walk_order(ref int ord[$]);
      ord = {};
      for (int r = 0; r < n_live; r++)
         for (int i = 0; i < SLOTS; i++)
            if (t_live[i] && t_rank[i] == r) begin
               ord.push_back(i);
               break;
            end
   endfunction

   function automatic void predict_events(req_type r);
      int s;
      int ord[$];
      s = -1;
      case (r.command)
         CMD_CREATE: begin
            for (int i = 0; i < SLOTS; i++)
               if (!t_live[i]) begin
                  s = i;
                  break;
               end
            if (s < 0) begin
               push_event(KIND_ACK, 0, 0, ST_FULL, 1'b1);
            end else begin
               t_id[s] = id_next;
               id_next = (id_next == ID_TOP) ? 1 : id_next + 1;
               load(s, r);
               t_key[s] = r.group_key;
               t_live[s] = 1'b1;
               t_rank[s] = n_live;
               n_live++;
               if (t_flags[s][0]) push_event(KIND_INIT, t_id[s], t_tag[s], ST_OK, 1'b0);
               push_event(KIND_ACK, t_id[s], t_tag[s], ST_OK, 1'b1);
            end
         end
         CMD_RESET, CMD_RELEASE: begin
            s = find_id(r.target_id);
            if (s < 0) begin
               push_event(KIND_ACK, 0, 0, ST_NOTFOUND, 1'b1);
            end else if (r.command == CMD_RESET) begin
               load(s, r);
               if (t_flags[s][0]) push_event(KIND_INIT, t_id[s], t_tag[s], ST_OK, 1'b0);
               push_event(KIND_ACK, t_id[s], t_tag[s], ST_OK, 1'b1);
            end else begin
               drop_slot(s);
               push_event(KIND_ACK, t_id[s], t_tag[s], ST_OK, 1'b1);
            end
         end
         CMD_KEY: begin
            if (r.group_key != 0) begin
               walk_order(ord);
               foreach (ord[i]) if (t_key[ord[i]] == r.group_key) drop_slot(ord[i]);
            end
            push_event(KIND_ACK, 0, 0, ST_OK, 1'b1);
         end
         CMD_POLL: begin
            walk_order(ord);
            foreach (ord[i]) begin
               s = ord[i];
               if (t_dur[s] != 0 && elapsed(r.now_time, t_start[s]) >= t_dur[s]) begin
                  if (t_flags[s][2]) push_event(KIND_TIMEOUT, t_id[s], t_tag[s], ST_OK, 1'b0);
                  if (t_flags[s][4]) drop_slot(s);
               end else begin
                  if (t_flags[s][1])
                     push_event(KIND_PROGRESS, t_id[s], t_tag[s], ST_OK, 1'b0);
                  if (t_flags[s][3] && elapsed(r.now_time, t_mark[s]) >= t_per[s]) begin
                     t_mark[s] = r.now_time;
                     push_event(KIND_PERIODIC, t_id[s], t_tag[s], ST_OK, 1'b0);
                  end
               end
            end
            push_event(KIND_ACK, 0, 0, ST_OK, 1'b1);
         end
         default: push_event(KIND_ACK, 0, 0, ST_OK, 1'b1);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_events(req_data);
         if (!req_valid || req_ready) begin
            if (cmd_queue.size() > 0 && !(idling && $urandom_range(99) < 14)) begin
               req_data <= cmd_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (event_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected word expected none actual %p", $time, rsp_data);
            end else begin
               want = event_queue.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.timer_id !== want.timer_id ||
                   rsp_data.tag_out !== want.tag_out || rsp_data.status !== want.status ||
                   rsp_data.last !== want.last) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
               end
            end
         end
         if (holdoff_req && !holdoff_done) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(idling && $urandom_range(99) < 14);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("software_timer_pool_top_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_cmd(logic [2:0] c, logic [TW-1:0] now,
      logic [TW-1:0] tgt, logic [TW-1:0] dur, logic [TW-1:0] per, logic fr,
      logic [3:0] en, logic [TW-1:0] tg, logic [TW-1:0] k);
      req_type r;
      r.command = c; r.now_time = now; r.target_id = tgt; r.duration = dur;
      r.period = per; r.free_on_timeout = fr; r.event_enables = en;
      r.user_tag = tg; r.group_key = k;
      return r;
   endfunction

   function automatic logic [TW-1:0] pick_key();
      case ($urandom_range(4))
         0: return 0;
         1: return 32'hA5A5_0001;
         2: return 32'h0000_0002;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_cmd();
      logic [2:0]    c;
      logic [TW-1:0] tgt, dur;
      int unsigned   w;
      w = $urandom_range(99);
      if (w < 40) c = CMD_CREATE;
      else if (w < 65) c = CMD_POLL;
      else if (w < 80) c = CMD_RELEASE;
      else if (w < 90) c = CMD_RESET;
      else if (w < 97) c = CMD_KEY;
      else c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      if ($urandom_range(19) == 0) clk_now = $urandom;
      else clk_now = clk_now + $urandom_range(0, 60);
      case ($urandom_range(9))
         0: tgt = 0;
         1: tgt = $urandom;
         default: tgt = id_next - $urandom_range(1, 24);
      endcase
      case ($urandom_range(9))
         0: dur = 0;
         1: dur = $urandom;
         default: dur = $urandom_range(1, 300);
      endcase
      return make_cmd(c, clk_now, tgt, dur,
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 80),
                      1'($urandom), 4'($urandom), $urandom, pick_key());
   endfunction

   task automatic settle();
      while (cmd_queue.size() > 0 || req_valid || event_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      cmd_queue.push_back(make_cmd(CMD_POLL, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_KEY, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_RESET, 0, 5, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_UNUSED_LO, 1, 1, 1, 1, 1, 4'hF, 1, 1));
      cmd_queue.push_back(make_cmd(CMD_UNUSED_HI, 0, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_CREATE, 100, 0, 0, 0, 1, 4'hF, ID_TOP, ID_TOP));
      cmd_queue.push_back(make_cmd(CMD_CREATE, 100, ID_TOP, 10, 3, 1, 4'hF, 0, 7));
      cmd_queue.push_back(make_cmd(CMD_CREATE, ID_TOP, 0, 5, ID_TOP, 0, 4'hE, 3, 7));
      for (int i = 0; i < 14; i++)
         cmd_queue.push_back(make_cmd(CMD_CREATE, 100 + i, 0, 50 + i, 4, i[0],
                                      4'($urandom), $urandom, 9));
      cmd_queue.push_back(make_cmd(CMD_POLL, 105, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_POLL, 50, 0, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_RESET, 200, 2, 30, 0, 1, 4'hF, 32'h1234, 0));
      cmd_queue.push_back(make_cmd(CMD_RELEASE, 0, 1, 0, 0, 0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(CMD_KEY, 0, 0, 0, 0, 0, 0, 0, 9));
      cmd_queue.push_back(make_cmd(CMD_POLL, ID_TOP, 0, 0, 0, 0, 0, 0, 0));
      settle();

      for (int n = 0; n < 250; n++) begin
         while (cmd_queue.size() >= 4) @(posedge clock);
         if (n == 40) holdoff_req = 1'b1;
         if (n == 44) holdoff_req = 1'b0;
         idling = !(n >= 100 && n < 160);
         if (n == 200) settle();
         cmd_queue.push_back(random_cmd());
      end
      settle();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("software_timer_pool_top_tb: clean");
      else
         $display("software_timer_pool_top_tb: errors");
      $finish;
   end
endmodule
`default_nettype wire
